@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port checker file. They expect signals named
// i_clk and i_rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define RWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked property that is also checked during reset
`define RWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

@@ src/rwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rwm_pkg
// Types and constants for the running weighted mean block.
// ----------------------------------------------------------------------------
package rwm_pkg;

    // Accumulator and operand widths
    localparam int NUM_W  = 64;
    localparam int WT_W   = 32;
    localparam int ROOT_W = NUM_W / 2;

    // Mean kind register codes
    localparam logic MODE_ARITH = 1'b0;
    localparam logic MODE_QUAD  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NEG_WEIGHT = 2'd1;
    localparam logic [1:0] STATUS_ZERO_TOTAL = 2'd2;
    localparam logic [1:0] STATUS_SATURATED  = 2'd3;

    // Saturation limits
    localparam logic [NUM_W-1:0] NUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] NUM_MIN = {1'b1, {(NUM_W-1){1'b0}}};
    localparam logic [WT_W-1:0]  WT_MAX  = {WT_W{1'b1}};

    // Mean result clamp values (Q9.8, 17 bit signed): +32768 and -32768
    localparam logic [16:0] MEAN_POS_LIM = 17'h08000;
    localparam logic [16:0] MEAN_NEG_LIM = 17'h18000;

    // Input transfer payload
    typedef struct packed {
        logic signed [15:0] sample_value;
        logic signed [15:0] sample_weight;
        logic               restart;
    } t_rwm_in;

    // Output transfer payload
    typedef struct packed {
        logic signed [16:0] mean_result;
        logic [1:0]         status;
    } t_rwm_out;

endpackage

@@ src/rwm_div.sv @@
// ----------------------------------------------------------------------------
// rwm_div
// Bit-serial restoring divider: 64-bit unsigned dividend by 32-bit unsigned
// divisor, one quotient bit per cycle, quotient valid with the done pulse.
// ----------------------------------------------------------------------------
module rwm_div
    import rwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [WT_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [WT_W-1:0]  r_rem;
    logic [WT_W-1:0]  r_div;

    logic [WT_W:0]    rem_sh;
    logic [WT_W:0]    diff;
    logic             ge;

    // One trial subtraction per cycle
    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = (rem_sh >= {1'b0, r_div});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out at the top, quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[WT_W-1:0] : rem_sh[WT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/rwm_isqrt.sv @@
// ----------------------------------------------------------------------------
// rwm_isqrt
// Digit-serial floor square root of a 64-bit unsigned value, two radicand bits
// and one root bit per cycle.
// ----------------------------------------------------------------------------
module rwm_isqrt
    import rwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    // Bring in the next two bits and try root*4+1
    assign rem_sh = {r_rem, r_rad[NUM_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[NUM_W-3:0], 2'b00};
            r_rem  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ src/running_weighted_mean.sv @@
// ----------------------------------------------------------------------------
// running_weighted_mean
// Running weighted arithmetic or quadratic mean of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// One sample is in flight at a time; o_in_stall is low only while the block is
// idle, and a finished result waits in the output register so the next sample
// can be taken meanwhile. A sample with a negative weight goes from idle
// straight to done; a saturated or zero-weight result first passes the
// multiply, accumulate and check states. An arithmetic mean adds the bit-serial
// divider and a quadratic mean also the root unit, though a non-positive mean
// square skips both. Each transfer yields exactly one result transfer.
// ----------------------------------------------------------------------------
module running_weighted_mean
    import rwm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // sample channel
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_rwm_in  i_in_data,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_rwm_out o_out_data,
    // mean kind register
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL1  = 8'b0000_0010,
        S_MUL2  = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_SQRT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // Control and state registers
    t_state            r_state,   n_state;
    logic              r_kind;
    logic [NUM_W-1:0]  r_num,     n_num;
    logic [WT_W-1:0]   r_wt,      n_wt;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    logic signed [15:0] r_val;
    logic signed [15:0] r_wgt;
    logic signed [31:0] r_prod,   n_prod;
    logic signed [47:0] r_term,   n_term;
    logic               r_neg,    n_neg;
    t_rwm_out           r_res,    n_res;
    t_rwm_out           r_out;

    logic               in_xfer;
    logic               out_xfer;
    logic               out_load;

    logic signed [64:0] sum_ext;
    logic [WT_W:0]      wt_ext;
    logic [NUM_W-1:0]   num_mag;
    logic               num_sat;

    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [16:0]        quo_neg;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Saturating accumulation terms
    assign sum_ext = 65'(signed'(r_num)) + 65'(r_term);
    assign wt_ext  = {1'b0, r_wt} + {{(WT_W - 14){1'b0}}, r_wgt[14:0]};
    assign num_sat = (r_num == NUM_MAX) || (r_num == NUM_MIN) || (r_wt == WT_MAX);
    assign num_mag = r_num[NUM_W-1] ? (NUM_W'(0) - r_num) : r_num;
    assign quo_neg = 17'd0 - div_quo[16:0];

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_wt        = r_wt;
        n_prod      = r_prod;
        n_term      = r_term;
        n_neg       = r_neg;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;
        sqrt_start  = 1'b0;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.restart) begin
                        n_num = '0;
                        n_wt  = '0;
                    end
                    if (i_in_data.sample_weight[15]) begin
                        n_res.mean_result = '0;
                        n_res.status      = STATUS_NEG_WEIGHT;
                        n_state           = S_DONE;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                // value, or value squared in quadratic mode
                n_prod  = (r_kind == MODE_QUAD) ? (32'(r_val) * 32'(r_val)) : 32'(r_val);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_term  = 48'(r_prod) * 48'(r_wgt);
                n_state = S_ACC;
            end
            S_ACC: begin
                // numerator clamps at the signed limits, total at all ones
                if (sum_ext[64] != sum_ext[63]) begin
                    n_num = sum_ext[64] ? NUM_MIN : NUM_MAX;
                end else begin
                    n_num = sum_ext[NUM_W-1:0];
                end
                n_wt    = wt_ext[WT_W] ? WT_MAX : wt_ext[WT_W-1:0];
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res.mean_result = '0;
                if (num_sat) begin
                    n_res.status = STATUS_SATURATED;
                    n_state      = S_DONE;
                end else if (r_wt == '0) begin
                    n_res.status = STATUS_ZERO_TOTAL;
                    n_state      = S_DONE;
                end else if ((r_kind == MODE_QUAD) &&
                             (r_num[NUM_W-1] || (r_num == '0))) begin
                    // non-positive mean square has root zero
                    n_res.status = STATUS_OK;
                    n_state      = S_DONE;
                end else begin
                    n_res.status = STATUS_OK;
                    n_neg        = r_num[NUM_W-1];
                    div_start    = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_kind == MODE_QUAD) begin
                        sqrt_start = 1'b1;
                        n_state    = S_SQRT;
                    end else begin
                        // truncated quotient, clamped to +/-32768 (Q9.8 limits)
                        if (div_quo > NUM_W'(MEAN_POS_LIM)) begin
                            n_res.mean_result = r_neg ? MEAN_NEG_LIM : MEAN_POS_LIM;
                        end else begin
                            n_res.mean_result = r_neg ? quo_neg : div_quo[16:0];
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    if (sqrt_root > ROOT_W'(MEAN_POS_LIM)) begin
                        n_res.mean_result = MEAN_POS_LIM;
                    end else begin
                        n_res.mean_result = sqrt_root[16:0];
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= MODE_ARITH;
            r_num       <= '0;
            r_wt        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_wt        <= n_wt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_kind <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_val <= i_in_data.sample_value;
            r_wgt <= i_in_data.sample_weight;
        end
        r_prod <= n_prod;
        r_term <= n_term;
        r_neg  <= n_neg;
        r_res  <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // Bit-serial divider
    rwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_mag),
        .i_divisor  (r_wt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Digit-serial square root
    rwm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (div_quo),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/rwm_checker.sv @@
// ----------------------------------------------------------------------------
// rwm_port_assertions
// Port-level checks on the running weighted mean block, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwm_port_assertions
    import rwm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_rwm_out o_out_data
);

    // A stalled result holds
    `RWM_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "result changed under stall")

    // Only one sample in flight: after a transfer the input side stalls
    `RWM_ASSERT(a_one_in_flight, (i_in_valid && !o_in_stall) |=> o_in_stall, "second sample taken while busy")

    // Any status other than ok carries a zero mean
    `RWM_ASSERT(a_zero_on_error, (o_out_valid && (o_out_data.status != STATUS_OK)) |-> (o_out_data.mean_result == 17'd0), "nonzero mean with error status")

    // Reset leaves the block idle with no result pending
    `RWM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && !o_in_stall), "not idle after reset")

endmodule

bind running_weighted_mean rwm_port_assertions u_rwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ tb/rwm_checker.sv @@
// ----------------------------------------------------------------------------
// rwm_checker
// Watches the sample, result and mean kind ports of the running weighted mean
// block, keeps its own copy of the sums, predicts one result per sample
// transfer and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rwm_checker
    import rwm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_rwm_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_rwm_out i_out_data,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    output int       o_fail_count,
    output int       o_pending
);

    // Shadow state of the block
    logic               mean_kind;
    logic signed [63:0] num_acc;
    logic [31:0]        wt_acc;

    t_rwm_out pending_means[$];
    int       fail_total;
    int       pending_total;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // Signed 64-bit add that clamps instead of wrapping
    function automatic logic signed [63:0] sum_saturating(logic signed [63:0] a,
                                                          logic signed [63:0] b);
        logic [64:0] t;
        t = {a[63], a} + {b[63], b};
        if (t[64] != t[63])
            return t[64] ? NUM_MIN : NUM_MAX;
        return t[63:0];
    endfunction

    // Floor square root, one root bit per pass from the top down
    function automatic logic [31:0] floor_root(logic [63:0] x);
        logic [31:0] r;
        logic [31:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= x)
                r = trial;
        end
        return r;
    endfunction

    // Fold one sample into the shadow sums and work out the mean it reports
    function automatic t_rwm_out accumulate_sample(t_rwm_in s);
        t_rwm_out    res;
        longint      v;
        longint      w;
        longint      term;
        longint      divisor;
        longint      q;
        logic [32:0] wsum;
        logic [31:0] root;
        v = s.sample_value;
        w = s.sample_weight;
        res.mean_result = '0;
        res.status      = STATUS_OK;

        // restart clears before anything else, even for a rejected weight
        if (s.restart) begin
            num_acc = '0;
            wt_acc  = '0;
        end

        if (w < 0) begin
            res.status = STATUS_NEG_WEIGHT;
        end else begin
            term    = (mean_kind == MODE_QUAD) ? v * v * w : v * w;
            num_acc = sum_saturating(num_acc, term);
            wsum    = {1'b0, wt_acc} + {1'b0, w[31:0]};
            wt_acc  = wsum[32] ? WT_MAX : wsum[31:0];

            if (num_acc == NUM_MAX || num_acc == NUM_MIN || wt_acc == WT_MAX) begin
                res.status = STATUS_SATURATED;
            end else if (wt_acc == '0) begin
                res.status = STATUS_ZERO_TOTAL;
            end else begin
                divisor = longint'({32'd0, wt_acc});
                q       = num_acc / divisor;
                if (mean_kind == MODE_QUAD) begin
                    // negative mean square left by a mode change reads as zero
                    root = (q > 0) ? floor_root(q) : '0;
                    res.mean_result = (root > 32'd32768) ? MEAN_POS_LIM : root[16:0];
                end else begin
                    if (q > 32768)
                        res.mean_result = MEAN_POS_LIM;
                    else if (q < -32768)
                        res.mean_result = MEAN_NEG_LIM;
                    else
                        res.mean_result = q[16:0];
                end
            end
        end
        return res;
    endfunction

    // Predict on sample transfers, compare on result transfers
    always @(posedge i_clk) begin
        t_rwm_out want;
        if (!i_rst_n) begin
            mean_kind     = MODE_ARITH;
            num_acc       = '0;
            wt_acc        = '0;
            pending_means.delete();
            fail_total    = 0;
            pending_total = 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                pending_means.push_back(accumulate_sample(i_in_data));

            if (i_out_valid && !i_out_stall) begin
                if (pending_means.size() == 0) begin
                    $display("%0t unexpected result: mean_result %0d status %0d",
                             $time, i_out_data.mean_result, i_out_data.status);
                    fail_total++;
                end else begin
                    want = pending_means.pop_front();
                    if (i_out_data.mean_result !== want.mean_result) begin
                        $display("%0t mean_result mismatch: expected %0d, got %0d",
                                 $time, want.mean_result, i_out_data.mean_result);
                        fail_total++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $display("%0t status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_out_data.status);
                        fail_total++;
                    end
                end
            end

            if (i_cfg_we)
                mean_kind = i_cfg_wdata;

            pending_total = pending_means.size();
        end
    end

endmodule

@@ tb/tb_running_weighted_mean.sv @@
// ----------------------------------------------------------------------------
// tb_running_weighted_mean
// Stimulus for the running weighted mean block: a directed run over the
// field extremes, rejected and zero weights, restarts and mode changes in the
// middle of a series, then random phases in both mean kinds with random
// gaps and stalls on either side. The checker beside the block does the
// predicting and comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_running_weighted_mean;
    import rwm_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 250;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_rwm_in  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_rwm_out out_data;
    logic     cfg_we    = 1'b0;
    logic     cfg_wdata = 1'b0;

    int fail_count;
    int pending;
    int in_idle_max  = 4;
    int out_idle_max = 4;
    int stalled_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    running_weighted_mean uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    rwm_checker u_mean_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: random stall before each result transfer
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            n = $urandom_range(0, out_idle_max);
            out_stall = (n != 0);
            repeat (n) @(negedge i_clk);
            out_stall = 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    // Present one sample after a random gap and hold it until taken.
    // Returns at the falling edge after the transfer with valid still high.
    task automatic send_sample(t_rwm_in s);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data  = s;
        in_valid = 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic push_sample(logic [15:0] v, logic [15:0] w, logic r);
        t_rwm_in s;
        s.sample_value  = v;
        s.sample_weight = w;
        s.restart       = r;
        send_sample(s);
    endtask

    // Hold off the sender until every result is back and the block is quiet
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mean_kind(logic kind);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = kind;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // Values lean towards the extremes, zero and small values; the rest is uniform
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly valid weights building up a series, some rejected ones
    function automatic t_rwm_in random_sample();
        t_rwm_in s;
        s.sample_value = pick_value();
        case ($urandom_range(0, 9))
            0: s.sample_weight = {1'b1, 15'($urandom)};
            1: s.sample_weight = 16'h0000;
            2: s.sample_weight = 16'h7FFF;
            default: s.sample_weight = {1'b0, 15'($urandom)};
        endcase
        s.restart = ($urandom_range(0, 11) == 0);
        return s;
    endfunction

    // Main sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Arithmetic mean from reset
        push_sample(16'h0000, 16'h0000, 1'b0);   // zero total weight
        push_sample(16'h7FFF, 16'h7FFF, 1'b1);
        push_sample(16'h8000, 16'h7FFF, 1'b0);   // truncates toward zero
        push_sample(16'h8000, 16'h0001, 1'b1);   // most negative mean
        push_sample(16'h1234, 16'h8000, 1'b0);   // rejected weight
        push_sample(16'h0100, 16'hFFFF, 1'b1);   // restart with rejected weight
        push_sample(16'h0500, 16'h0000, 1'b0);   // sums cleared, total still zero
        push_sample(16'hFF00, 16'h0100, 1'b0);
        push_sample(16'hAAAA, 16'h5555, 1'b0);
        push_sample(16'h5555, 16'h2AAA, 1'b0);

        // Quadratic mean on a negative arithmetic series
        write_mean_kind(MODE_QUAD);
        push_sample(16'h0001, 16'h0001, 1'b0);   // negative mean square
        push_sample(16'h8000, 16'h0001, 1'b1);   // root hits the upper clamp
        push_sample(16'h7FFF, 16'h7FFF, 1'b0);
        push_sample(16'h0000, 16'h0000, 1'b1);
        push_sample(16'h0180, 16'h0200, 1'b0);
        push_sample(16'hFFFF, 16'h0001, 1'b0);
        push_sample(16'h4000, 16'hFFFF, 1'b0);

        // Back to arithmetic on quadratic sums
        write_mean_kind(MODE_ARITH);
        push_sample(16'h0100, 16'h0100, 1'b0);   // clamps high
        push_sample(16'h8000, 16'h7FFF, 1'b1);
        push_sample(16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h0080, 16'h0001, 1'b0);

        // Random phases: alternate kinds and idling patterns
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_mean_kind(phase[0] ? MODE_ARITH : MODE_QUAD);
            case (phase % 4)
                0: begin in_idle_max = 0; out_idle_max = 0; end
                1: begin in_idle_max = 4; out_idle_max = 4; end
                2: begin in_idle_max = 0; out_idle_max = 4; end
                default: begin in_idle_max = 4; out_idle_max = 0; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 1 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_sample(random_sample());
            end
        end

        // Drain and give the verdict
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ running_weighted_mean.f @@
+incdir+src
src/rwm_pkg.sv
src/rwm_div.sv
src/rwm_isqrt.sv
src/running_weighted_mean.sv
src/rwm_checker.sv
tb/rwm_checker.sv
tb/tb_running_weighted_mean.sv
